// ===== rtl/b2da_pkg.sv =====
package b2da_pkg;

    localparam int VALUE_W        = 64;
    localparam int STEP_W         = $clog2(VALUE_W);
    localparam int CHAR_W         = 6;
    localparam int COUNT_W        = 5;
    localparam int CAP_W          = 5;
    localparam int OUT_DATA_W     = 16;
    localparam int MAX_DIGITS_DEF = 20;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(21);
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Status from the conversion core to the sequencer.
    typedef struct packed {
        logic done;  // one-cycle pulse after the last shift step
        logic ovf;   // a nonzero bit left the top digit
    } t_core_stat;

endpackage

// ===== rtl/b2da_dabble.sv =====
module b2da_dabble #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [b2da_pkg::VALUE_W-1:0] i_value,
    output logic [4*MAX_DIGITS-1:0]      o_bcd,
    output b2da_pkg::t_core_stat         o_stat
);
    import b2da_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;
    logic               r_ovf;
    logic [BCD_W-1:0]   adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(VALUE_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin  <= i_value;
            r_bcd  <= '0;
            r_step <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_bin  <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd  <= {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_step <= r_step + STEP_W'(1);
            r_ovf  <= r_ovf | adj[BCD_W-1];
        end
    end

    assign o_bcd       = r_bcd;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;

endmodule

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// Unsigned 64-bit binary to decimal ASCII converter. Each request on the
// s_axis side carries one value; the block answers with one m_axis request
// per decimal digit, most significant first, each carrying the ASCII digit,
// the digit count of the conversion and tlast on the final digit. The
// capacity register (cfg port, reset 21) allows at most capacity - 1 digits;
// a longer number keeps its low-order digits. A capacity below 2 gives one
// request flagged empty in tuser, and a zero value otherwise gives "0".
// Timing: the block takes one value at a time and deasserts s_axis_tready
// from acceptance until the last digit is taken. The conversion is a
// bit-serial double dabble over all 64 input bits, then a leading-zero scan
// walks down from the top digit one position a cycle, then one digit leaves
// per cycle while m_axis_tready is high. A capacity below 2 skips the
// conversion and the scan and offers the empty result directly.
// Write the capacity only while the block is idle.
module binary_to_decimal_ascii_top #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write: buffer_capacity
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [b2da_pkg::CAP_W-1:0]      i_cfg_data,
    // input stream, tdata: value[63:0]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [b2da_pkg::VALUE_W-1:0]    s_axis_tdata,
    // output stream, tdata: digit_char[5:0], digit_count[10:6], zeros above
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [b2da_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: no_digits
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import b2da_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PAD_W = OUT_DATA_W - CHAR_W - COUNT_W;

    t_state             r_state, n_state;
    logic [CAP_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_limit, n_limit;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_empty, n_empty;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_last, n_last;

    logic               core_start;
    logic [4*MAX_DIGITS-1:0] bcd;
    t_core_stat         stat;

    logic [CAP_W-1:0]   cap_lim;
    logic [CNT_W-1:0]   sig_digits;
    logic [CNT_W-1:0]   n_digits;
    logic [IDX_W-1:0]   top_idx;
    logic               in_acc;
    logic               out_acc;

    b2da_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_value (s_axis_tdata),
        .o_bcd   (bcd),
        .o_stat  (stat)
    );

    function automatic logic [3:0] digit_at(input logic [4*MAX_DIGITS-1:0] store,
                                            input logic [IDX_W-1:0] idx);
        digit_at = store[4*idx +: 4];
    endfunction

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Digit limit from capacity: capacity - 1, saturated at MAX_DIGITS.
    always_comb begin
        if (r_cap == '0) begin
            cap_lim = '0;
        end else begin
            cap_lim = r_cap - CAP_W'(1);
        end
        if (cap_lim > CAP_W'(MAX_DIGITS)) begin
            cap_lim = CAP_W'(MAX_DIGITS);
        end
    end

    // Significant digits at the scan position, clipped to the limit.
    always_comb begin
        if (stat.ovf) begin
            sig_digits = CNT_W'(MAX_DIGITS);
        end else begin
            sig_digits = CNT_W'(r_idx) + CNT_W'(1);
        end
        if (sig_digits > r_limit) begin
            n_digits = r_limit;
        end else begin
            n_digits = sig_digits;
        end
        top_idx = IDX_W'(n_digits - CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cap    <= CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        r_idx   <= n_idx;
        r_char  <= n_char;
        r_empty <= n_empty;
        r_count <= n_count;
        r_last  <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_limit    = r_limit;
        n_idx      = r_idx;
        n_ovalid   = r_ovalid;
        n_char     = r_char;
        n_empty    = r_empty;
        n_count    = r_count;
        n_last     = r_last;
        core_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_limit = CNT_W'(cap_lim);
                    if (cap_lim == '0) begin
                        // No room for a digit: answer with the empty result.
                        n_char   = '0;
                        n_empty  = 1'b1;
                        n_count  = '0;
                        n_last   = 1'b1;
                        n_ovalid = 1'b1;
                        n_state  = ST_EMIT;
                    end else begin
                        core_start = 1'b1;
                        n_state    = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                if (stat.done) begin
                    n_idx   = IDX_W'(MAX_DIGITS - 1);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Walk down past leading zeros; the lowest digit always counts.
                if (stat.ovf || digit_at(bcd, r_idx) != 4'd0 || r_idx == '0) begin
                    n_idx    = top_idx;
                    n_char   = ASCII_ZERO + CHAR_W'(digit_at(bcd, top_idx));
                    n_empty  = 1'b0;
                    n_count  = n_digits;
                    n_last   = (top_idx == '0);
                    n_ovalid = 1'b1;
                    n_state  = ST_EMIT;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (r_last) begin
                        n_ovalid = 1'b0;
                        n_state  = ST_IDLE;
                    end else begin
                        // Advance to the next lower digit.
                        n_idx  = r_idx - IDX_W'(1);
                        n_char = ASCII_ZERO + CHAR_W'(digit_at(bcd, r_idx - IDX_W'(1)));
                        n_last = (r_idx == IDX_W'(1));
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, COUNT_W'(r_count), r_char};
    assign m_axis_tuser  = r_empty;
    assign m_axis_tlast  = r_last;

endmodule

// ===== test/testbench.sv =====
module testbench;
    import b2da_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEMS_PER_CAP = 41;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               empty;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_digit_rec;

    // Expected digits of every accepted value, in output order.
    class decimal_scoreboard;
        t_digit_rec       digits_due[$];
        logic [CAP_W-1:0] capacity;
        int               mismatches;

        function new();
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return digits_due.size();
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Convert an accepted value and queue the digits it must produce.
        function void note_value(input logic [VALUE_W-1:0] value);
            logic [3:0]         digs [MAX_DIGITS_DEF];
            logic [VALUE_W-1:0] rest;
            int                 lim;
            int                 n;
            t_digit_rec         rec;
            lim  = (capacity == 0) ? 0 : int'(capacity) - 1;
            rest = value;
            n    = 0;
            if (lim > MAX_DIGITS_DEF) lim = MAX_DIGITS_DEF;
            if (lim == 0) begin
                rec = '{ch: '0, empty: 1'b1, count: '0, last: 1'b1};
                digits_due.push_back(rec);
                return;
            end
            if (rest == 0) begin
                digs[0] = 4'd0;
                n = 1;
            end else begin
                // keep the low-order digits when the number is too long
                while (rest != 0 && n < lim) begin
                    digs[n] = 4'(rest % 64'd10);
                    rest    = rest / 64'd10;
                    n++;
                end
            end
            for (int k = 0; k < n; k++) begin
                rec.ch    = ASCII_ZERO + CHAR_W'(digs[n - 1 - k]);
                rec.empty = 1'b0;
                rec.count = COUNT_W'(n);
                rec.last  = (k == n - 1);
                digits_due.push_back(rec);
            end
        endfunction

        task check_digit(input logic [OUT_DATA_W-1:0] data, input logic user,
                         input logic lst);
            t_digit_rec want;
            if (digits_due.size() == 0) begin
                report_mismatch($sformatf("digit %h with no pending request", data));
                return;
            end
            want = digits_due.pop_front();
            if (data[CHAR_W-1:0] !== want.ch)
                report_mismatch($sformatf("digit_char %0d, want %0d",
                                          data[CHAR_W-1:0], want.ch));
            if (data[CHAR_W +: COUNT_W] !== want.count)
                report_mismatch($sformatf("digit_count %0d, want %0d",
                                          data[CHAR_W +: COUNT_W], want.count));
            if (data[OUT_DATA_W-1:CHAR_W+COUNT_W] !== '0)
                report_mismatch($sformatf("tdata pad bits %h not zero", data));
            if (user !== want.empty)
                report_mismatch($sformatf("no_digits %b, want %b", user, want.empty));
            if (lst !== want.last)
                report_mismatch($sformatf("last %b, want %b", lst, want.last));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CAP_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [VALUE_W-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    decimal_scoreboard sb;
    int                digits_taken;
    bit                idling_on;

    binary_to_decimal_ascii_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [VALUE_W-1:0] pow10(input int k);
        logic [VALUE_W-1:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p;
    endfunction

    // Bias toward short numbers and decade boundaries, where the digit
    // count and the trimming of long numbers change.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return full;
            3, 4, 5: return full >> $urandom_range(0, 63);
            6, 7:    return pow10($urandom_range(0, 19)) +
                            VALUE_W'($urandom_range(0, 2)) - 64'd1;
            8:       return VALUE_W'($urandom_range(0, 999));
            default: return full | (64'd1 << 63);
        endcase
    endfunction

    // Offer one value after a random gap; return once it is taken.
    task send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_value(value);
    endtask

    // Drop the input and wait until every digit has come out.
    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.capacity = cap;
        i_cfg_valid <= 1'b0;
    endtask

    // Take every digit request that completes a handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_digit(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            digits_taken++;
        end
    end

    // Output side: random ready stretches, and once a long hold-off so the
    // block backs up and stalls its input while requests keep coming.
    initial begin
        int  run;
        int  hold;
        bit  ready_now;
        bit  pressure_done;
        ready_now     = 1'b0;
        pressure_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressure_done && digits_taken >= 600) begin
                pressure_done = 1'b1;
                if (ready_now) m_axis_tready <= 1'b0;
                ready_now = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (!ready_now) m_axis_tready <= 1'b1;
            ready_now = 1'b1;
            run = $urandom_range(1, 30);
            repeat (run) @(posedge i_clk);
            hold = pick_gap();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                ready_now = 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [VALUE_W-1:0] directed [13];
        logic [CAP_W-1:0]   caps [10];
        sb            = new();
        digits_taken  = 0;
        idling_on     = 1'b1;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;

        // Zero, decade edges, the largest value and alternating bit patterns.
        directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'd10000000000000000000,
                     64'd9999999999999999999, 64'h8000_0000_0000_0000,
                     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'd12345678901234567890};
        // Capacity sweep: empty results, a single digit, values past the
        // documented range, the reset value and a few in between.
        caps = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd22, 5'd3, 5'd11, 5'd20, 5'd21, 5'd7};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset capacity.
        foreach (directed[i]) send_value(directed[i]);
        drain();

        foreach (caps[ph]) begin
            idling_on = (ph % 4 != 3);
            write_capacity(caps[ph]);
            send_value('0);
            send_value('1);
            repeat (ITEMS_PER_CAP - 2) send_value(random_value());
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
